// ----- design/bdmp_pkg.sv -----
// Shared types and constants for the button debounce and multi-press detector
package bdmp_pkg;

  // Item kind
  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Register index, taken from paddr[3:2]
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_WINDOW   = 2'd1;
  localparam logic [1:0] REG_TRIGGER  = 2'd2;

  // Register reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] WINDOW_RST   = 16'd2000;
  localparam logic [7:0]  TRIGGER_RST  = 8'd5;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [15:0] press_window;
    logic [7:0]  trigger_press_count;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [31:0] time_ms;
    logic        pin_level;
  } item_t;

  typedef struct packed {
    logic [31:0] last_edge_time;
    logic        previous_level_high;
    logic [7:0]  window_count;
    logic [31:0] window_start_time;
    logic [31:0] press_time;
  } state_t;

  typedef struct packed {
    logic        press_event;
    logic        trigger_event;
    logic [7:0]  press_total;
    logic [31:0] last_press_time;
  } result_t;

endpackage

// ----- design/bdmp_regs.sv -----
// APB-style configuration registers
module bdmp_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output bdmp_pkg::cfg_t       cfg
);

  bdmp_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // Register write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time       <= bdmp_pkg::DEBOUNCE_RST;
      cfg_r.press_window        <= bdmp_pkg::WINDOW_RST;
      cfg_r.trigger_press_count <= bdmp_pkg::TRIGGER_RST;
    end else if (wr_en) begin
      case (reg_idx)
        bdmp_pkg::REG_DEBOUNCE: cfg_r.debounce_time       <= pwdata[15:0];
        bdmp_pkg::REG_WINDOW:   cfg_r.press_window        <= pwdata[15:0];
        bdmp_pkg::REG_TRIGGER:  cfg_r.trigger_press_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    case (reg_idx)
      bdmp_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg_r.debounce_time};
      bdmp_pkg::REG_WINDOW:   prdata = {16'd0, cfg_r.press_window};
      bdmp_pkg::REG_TRIGGER:  prdata = {24'd0, cfg_r.trigger_press_count};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

// ----- design/bdmp_step.sv -----
// Per-item debounce, press window and trigger logic (combinational)
module bdmp_step (
  input  bdmp_pkg::cfg_t    cfg,
  input  bdmp_pkg::item_t   item,
  input  bdmp_pkg::state_t  st,
  output bdmp_pkg::state_t  st_nxt,
  output bdmp_pkg::result_t res
);

  logic [31:0] edge_gap;
  logic [31:0] win_gap;
  logic        win_expired;
  logic        debounced_ok;
  logic        press;
  logic        trig;

  // Wrapping time differences
  assign edge_gap     = item.time_ms - st.last_edge_time;
  assign win_gap      = item.time_ms - st.window_start_time;
  assign win_expired  = win_gap > {16'd0, cfg.press_window};
  assign debounced_ok = edge_gap >= {16'd0, cfg.debounce_time};

  // State update
  always_comb begin
    st_nxt = st;
    press  = 1'b0;
    trig   = 1'b0;
    if (item.action == bdmp_pkg::ACT_EDGE) begin
      if (debounced_ok) begin
        st_nxt.last_edge_time = item.time_ms;
        // high-to-low transition is a press
        if (!item.pin_level && st.previous_level_high) begin
          press             = 1'b1;
          st_nxt.press_time = item.time_ms;
          if (st.window_count == 8'd0 || win_expired) begin
            st_nxt.window_start_time = item.time_ms;
            st_nxt.window_count      = 8'd1;
          end else if (st.window_count != bdmp_pkg::COUNT_MAX) begin
            st_nxt.window_count = st.window_count + 8'd1;
          end
          trig = st_nxt.window_count >= cfg.trigger_press_count;
        end
        st_nxt.previous_level_high = item.pin_level;
      end
    end else begin
      // tick: drop an incomplete sequence once its window has run out
      if (st.window_count != 8'd0 && win_expired &&
          st.window_count < cfg.trigger_press_count) begin
        st_nxt.window_count = 8'd0;
      end
    end
  end

  // Result
  always_comb begin
    res.press_event     = press;
    res.trigger_event   = trig;
    res.press_total     = st_nxt.window_count;
    res.last_press_time = st_nxt.press_time;
  end

endmodule

// ----- design/button_debounce_multi_press_core.sv -----
// Button debounce and multi-press detector, top level
// An item passes the input register, then the result register, before its result appears.
// One item per cycle while the result channel is not stalled; the state update for an item
// is evaluated combinationally between the input register and the result register.
// Reset (synchronous, rst_n low): pipeline empties, detector state and configuration
// registers return to their defaults (debounce 50, window 2000, threshold 5).
module button_debounce_multi_press_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_time_ms,
  input  logic        in_pin_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_press_event,
  output logic        out_trigger_event,
  output logic [7:0]  out_press_total,
  output logic [31:0] out_last_press_time
);

  bdmp_pkg::cfg_t    cfg;
  bdmp_pkg::item_t   s1_item_r;
  logic              s1_valid_r;
  bdmp_pkg::state_t  st_r;
  bdmp_pkg::state_t  st_nxt;
  bdmp_pkg::result_t res_nxt;
  bdmp_pkg::result_t out_res_r;
  logic              out_valid_r;
  logic              s1_adv;
  logic              in_xfer;

  bdmp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdmp_step u_step (
    .cfg    (cfg),
    .item   (s1_item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Handshake: input stage moves on when the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.action    <= in_action;
      s1_item_r.time_ms   <= in_time_ms;
      s1_item_r.pin_level <= in_pin_level;
    end
  end

  // Detector state, updated as each item is evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.last_edge_time      <= 32'd0;
      st_r.previous_level_high <= 1'b1;
      st_r.window_count        <= 8'd0;
      st_r.window_start_time   <= 32'd0;
      st_r.press_time          <= 32'd0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_press_event     = out_res_r.press_event;
  assign out_trigger_event   = out_res_r.trigger_event;
  assign out_press_total     = out_res_r.press_total;
  assign out_last_press_time = out_res_r.last_press_time;

endmodule

// ----- design/bdmp_chk.sv -----
// Port-level checker for the detector, bound to the top level
module bdmp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_press_event,
  input logic        out_trigger_event,
  input logic [7:0]  out_press_total,
  input logic [31:0] out_last_press_time
);

  // Pipeline is empty the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_press_event) &&
      $stable(out_trigger_event) && $stable(out_press_total) &&
      $stable(out_last_press_time))
    else $error("stalled result changed");

  // Trigger only comes with a press
  a_trig_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger_event |-> out_press_event)
    else $error("trigger without press");

  // A press always leaves a non-empty window
  a_press_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_press_event |-> out_press_total != 8'd0)
    else $error("press with zero count");

endmodule

bind button_debounce_multi_press_core bdmp_chk u_bdmp_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_press_event     (out_press_event),
  .out_trigger_event   (out_trigger_event),
  .out_press_total     (out_press_total),
  .out_last_press_time (out_last_press_time)
);
